### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, masked while i_rst_n is low.
`define FSK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define FSK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### design/fsk_pkg.sv
// ----------------------------------------------------------------------------
// fsk_pkg
// Types and constants of the fan speed kick-start controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsk_pkg;

    localparam int unsigned ADC_W   = 10;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned KICK_W  = 16;
    localparam int unsigned SPEED_W = 2;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDAT_W  = 16;

    typedef logic [ADC_W-1:0]   t_adc;
    typedef logic [PCT_W-1:0]   t_pct;
    typedef logic [DUTY_W-1:0]  t_duty;
    typedef logic [KICK_W-1:0]  t_kick;
    typedef logic [CDAT_W-1:0]  t_cfg_data;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef enum logic [SPEED_W-1:0] {
        SPEED_OFF  = 2'd0,
        SPEED_LOW  = 2'd1,
        SPEED_MID  = 2'd2,
        SPEED_HIGH = 2'd3
    } t_speed;

    typedef enum logic [CIDX_W-1:0] {
        CFG_THRESH_LOW  = 3'd0,
        CFG_THRESH_MID  = 3'd1,
        CFG_THRESH_HIGH = 3'd2,
        CFG_DUTY_LOW    = 3'd3,
        CFG_DUTY_MID    = 3'd4,
        CFG_DUTY_HIGH   = 3'd5,
        CFG_KICK_MS     = 3'd6
    } t_cfg_idx;

    localparam t_adc  THRESH_LOW_RST  = 10'd401;
    localparam t_adc  THRESH_MID_RST  = 10'd601;
    localparam t_adc  THRESH_HIGH_RST = 10'd801;
    localparam t_pct  DUTY_LOW_RST    = 7'd40;
    localparam t_pct  DUTY_MID_RST    = 7'd70;
    localparam t_pct  DUTY_HIGH_RST   = 7'd100;
    localparam t_kick KICK_MS_RST     = 16'd400;

    localparam int unsigned PCT_MAX = 100;

endpackage

### design/fsk_if.sv
// ----------------------------------------------------------------------------
// fsk_if
// Valid/ready channels of the fan speed kick-start controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsk_in_if;
    import fsk_pkg::*;
    logic valid;
    logic ready;
    t_op  operation;
    t_adc adc_sample;

    modport source (output valid, output operation, output adc_sample, input ready);
    modport sink   (input valid, input operation, input adc_sample, output ready);
endinterface

interface fsk_out_if;
    import fsk_pkg::*;
    logic   valid;
    logic   ready;
    t_speed speed_level;
    t_duty  duty_count;
    logic   kick_active;
    logic   duty_changed;

    modport source (output valid, output speed_level, output duty_count,
                    output kick_active, output duty_changed, input ready);
    modport sink   (input valid, input speed_level, input duty_count,
                    input kick_active, input duty_changed, output ready);
endinterface

interface fsk_cfg_if;
    import fsk_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/fan_speed_kickstart_controller.sv
// ----------------------------------------------------------------------------
// fan_speed_kickstart_controller
// Gas-sensor driven fan speed selection with a kick-start from standstill.
// ----------------------------------------------------------------------------
// Each input transfer is either an ADC sample or a one-millisecond tick and
// yields exactly one result, offered the cycle after it is taken. A new item
// is taken in every cycle, so throughput is one item per clock; the only thing
// that holds the input back is a result still waiting in the output register
// while the sink is not ready. A sample is mapped to speed 0..3 by three
// thresholds (checked high, mid, low). On a level change the duty count comes
// from that level's percent as pct*4*(PERIOD_REG+1)/100, clamped to
// 4*(PERIOD_REG+1)-1; the percent-to-count conversion is an elaboration-time
// constant table, so no divider is in the datapath. Going from off to speed 1
// first drives the high duty for kick_ms ticks (samples are dropped while the
// kick runs), then the tick that ends the kick sets the low duty. The user is
// to write registers only while idle; configuration writes are never blocked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_speed_kickstart_controller #(
    parameter int unsigned PERIOD_REG = 79   // PWM period register, 1..255
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsk_in_if.sink    i_in,
    fsk_out_if.source o_out,
    fsk_cfg_if.sink   i_cfg
);
    import fsk_pkg::*;

    // Full-scale PWM count; the top duty is one below it.
    localparam int unsigned FULL     = 4 * (PERIOD_REG + 1);
    localparam int unsigned PCT_CNT  = 2 ** PCT_W;

    // ---- percent to duty count table (constants) ---------------------------
    t_duty w_pct_cnt [PCT_CNT];

    for (genvar g = 0; g < PCT_CNT; g++) begin : g_pct_tbl
        // Percent above 100 behaves as 100.
        localparam int unsigned PCT_EFF = (g > PCT_MAX) ? PCT_MAX : g;
        localparam int unsigned RAW     = (PCT_EFF * FULL) / PCT_MAX;
        localparam int unsigned CLAMPED = (RAW >= FULL) ? (FULL - 1) : RAW;
        assign w_pct_cnt[g] = t_duty'(CLAMPED);
    end

    // ---- configuration registers -------------------------------------------
    t_adc  r_thr_low, r_thr_mid, r_thr_high;
    t_pct  r_pct_low, r_pct_mid, r_pct_high;
    t_kick r_kick_ms;

    logic w_cfg_xfer;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_xfer  = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_low  <= THRESH_LOW_RST;
            r_thr_mid  <= THRESH_MID_RST;
            r_thr_high <= THRESH_HIGH_RST;
            r_pct_low  <= DUTY_LOW_RST;
            r_pct_mid  <= DUTY_MID_RST;
            r_pct_high <= DUTY_HIGH_RST;
            r_kick_ms  <= KICK_MS_RST;
        end else if (w_cfg_xfer) begin
            case (i_cfg.index)
                CFG_THRESH_LOW:  r_thr_low  <= i_cfg.data[ADC_W-1:0];
                CFG_THRESH_MID:  r_thr_mid  <= i_cfg.data[ADC_W-1:0];
                CFG_THRESH_HIGH: r_thr_high <= i_cfg.data[ADC_W-1:0];
                CFG_DUTY_LOW:    r_pct_low  <= i_cfg.data[PCT_W-1:0];
                CFG_DUTY_MID:    r_pct_mid  <= i_cfg.data[PCT_W-1:0];
                CFG_DUTY_HIGH:   r_pct_high <= i_cfg.data[PCT_W-1:0];
                CFG_KICK_MS:     r_kick_ms  <= i_cfg.data[KICK_W-1:0];
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    // ---- controller state ---------------------------------------------------
    t_speed r_speed, n_speed;
    t_kick  r_kick,  n_kick;
    t_duty  r_duty,  n_duty;

    // ---- output register ----------------------------------------------------
    logic   r_out_valid;
    t_speed r_out_speed;
    t_duty  r_out_duty;
    logic   r_out_kick;
    logic   r_out_chg;

    logic   w_in_xfer;
    t_speed w_level;
    t_duty  w_duty_low, w_duty_mid, w_duty_high;

    // Take a new item whenever the output slot is empty or drains this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    assign w_duty_low  = w_pct_cnt[r_pct_low];
    assign w_duty_mid  = w_pct_cnt[r_pct_mid];
    assign w_duty_high = w_pct_cnt[r_pct_high];

    // Threshold priority: high wins over mid wins over low.
    always_comb begin
        if (i_in.adc_sample >= r_thr_high) begin
            w_level = SPEED_HIGH;
        end else if (i_in.adc_sample >= r_thr_mid) begin
            w_level = SPEED_MID;
        end else if (i_in.adc_sample >= r_thr_low) begin
            w_level = SPEED_LOW;
        end else begin
            w_level = SPEED_OFF;
        end
    end

    always_comb begin
        n_speed = r_speed;
        n_kick  = r_kick;
        n_duty  = r_duty;
        if (w_in_xfer) begin
            if (i_in.operation == OP_SAMPLE) begin
                // Samples are dropped while the kick runs.
                if (r_kick == '0 && w_level != r_speed) begin
                    case (w_level)
                        SPEED_OFF: n_duty = '0;
                        SPEED_LOW: begin
                            if (r_speed == SPEED_OFF && r_kick_ms != '0) begin
                                n_duty = w_duty_high;
                                n_kick = r_kick_ms;
                            end else begin
                                n_duty = w_duty_low;
                            end
                        end
                        SPEED_MID:  n_duty = w_duty_mid;
                        SPEED_HIGH: n_duty = w_duty_high;
                        default:    n_duty = r_duty;
                    endcase
                    n_speed = w_level;
                end
            end else if (r_kick != '0) begin
                n_kick = r_kick - KICK_W'(1);
                // Last tick of the kick falls back to the low duty.
                if (r_kick == KICK_W'(1)) begin
                    n_duty = w_duty_low;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_OFF;
            r_kick  <= '0;
            r_duty  <= '0;
        end else begin
            r_speed <= n_speed;
            r_kick  <= n_kick;
            r_duty  <= n_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: loaded with the post-item state on every input transfer.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_speed <= n_speed;
            r_out_duty  <= n_duty;
            r_out_kick  <= (n_kick != '0);
            r_out_chg   <= (n_duty != r_duty);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.speed_level  = r_out_speed;
    assign o_out.duty_count   = r_out_duty;
    assign o_out.kick_active  = r_out_kick;
    assign o_out.duty_changed = r_out_chg;

endmodule

### design/fsk_checker.sv
// ----------------------------------------------------------------------------
// fsk_checker
// Port-level assertions for the fan speed kick-start controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsk_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [1:0]             i_out_speed,
    input fsk_pkg::t_duty         i_out_duty,
    input logic                   i_out_kick
);
    import fsk_pkg::*;

    // A result waiting on the sink stays offered.
    `FSK_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")

    // Every input transfer shows up as a result on the next cycle.
    `FSK_ASSERT(a_in_to_out, i_in_valid && i_in_ready |=> i_out_valid, "input transfer without result")

    // The kick only runs at speed 1.
    `FSK_ASSERT(a_kick_speed, i_out_valid && i_out_kick |-> i_out_speed == SPEED_LOW, "kick at wrong speed")

    // Fan off means zero duty.
    `FSK_ASSERT(a_off_duty, i_out_valid && i_out_speed == SPEED_OFF |-> i_out_duty == '0, "duty while off")

endmodule

bind fan_speed_kickstart_controller fsk_checker u_fsk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_speed (o_out.speed_level),
    .i_out_duty  (o_out.duty_count),
    .i_out_kick  (o_out.kick_active)
);

### sim/fan_speed_kickstart_controller_tb.sv
// ----------------------------------------------------------------------------
// fan_speed_kickstart_controller_tb
// Self-checking bench for the fan speed kick-start controller.
// ----------------------------------------------------------------------------
// A tracker class mirrors the controller: register file, speed level, kick
// countdown and duty count. Each input transfer is folded into the tracker
// and leaves one predicted fan state in a queue; each output transfer is
// popped against the oldest prediction, field by field. Stimulus is a
// directed opening, a back-pressure burst, a set of randomized register
// settings with mostly well-formed off -> speed 1 -> tick runs, and a final
// stretch without idling that runs a long kick to the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_speed_kickstart_controller_tb;
    import fsk_pkg::*;

    localparam int unsigned PERIOD_REG     = 79;
    localparam int unsigned ADC_MAX        = (1 << ADC_W) - 1;
    localparam int          FINAL_KICK     = 48;      // kick length of the last stretch
    localparam int          DRAIN_CYCLES   = 4;       // output register plus margin
    localparam int          HOLD_CYCLES    = 200;     // long sink hold-off
    localparam int          TIMEOUT_CYCLES = 1000000;
    localparam int          MAX_PRINTED    = 40;
    localparam int          RAND_PHASES    = 8;
    localparam int          PHASE_ITEMS    = 70;
    localparam logic [CIDX_W-1:0] CFG_IDX_UNUSED = 3'd7;  // not mapped to a register

    typedef struct packed {
        t_speed speed;
        t_duty  duty;
        logic   kick;
        logic   changed;
    } t_fan_state;

    // ------------------------------------------------------------------------
    // Tracker: register copy, controller state, predicted fan states
    // ------------------------------------------------------------------------
    class t_fan_tracker;
        t_adc       thr_low, thr_mid, thr_high;
        t_pct       pct_low, pct_mid, pct_high;
        t_kick      kick_len;
        t_speed     speed;
        t_kick      kick_left;
        t_duty      duty;
        t_fan_state fan_state_q[$];
        int         n_checked;
        int         n_kicks;

        function new();
            thr_low   = THRESH_LOW_RST;
            thr_mid   = THRESH_MID_RST;
            thr_high  = THRESH_HIGH_RST;
            pct_low   = DUTY_LOW_RST;
            pct_mid   = DUTY_MID_RST;
            pct_high  = DUTY_HIGH_RST;
            kick_len  = KICK_MS_RST;
            speed     = SPEED_OFF;
            kick_left = '0;
            duty      = '0;
            n_checked = 0;
            n_kicks   = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, t_cfg_data d);
            case (t_cfg_idx'(idx))
                CFG_THRESH_LOW:  thr_low  = d[ADC_W-1:0];
                CFG_THRESH_MID:  thr_mid  = d[ADC_W-1:0];
                CFG_THRESH_HIGH: thr_high = d[ADC_W-1:0];
                CFG_DUTY_LOW:    pct_low  = d[PCT_W-1:0];
                CFG_DUTY_MID:    pct_mid  = d[PCT_W-1:0];
                CFG_DUTY_HIGH:   pct_high = d[PCT_W-1:0];
                CFG_KICK_MS:     kick_len = d[KICK_W-1:0];
                default: ;
            endcase
        endfunction

        // percent above 100 saturates; the top duty is one below full scale
        function t_duty pct_to_duty(t_pct p);
            int unsigned full;
            int unsigned pc;
            int unsigned cnt;
            full = 4 * (PERIOD_REG + 1);
            pc   = (p > PCT_MAX) ? PCT_MAX : p;
            cnt  = (pc * full) / 100;
            if (cnt >= full) cnt = full - 1;
            return t_duty'(cnt);
        endfunction

        // thresholds are checked high first, so an unordered set still resolves
        function t_speed level_of(t_adc a);
            if (a >= thr_high) return SPEED_HIGH;
            if (a >= thr_mid)  return SPEED_MID;
            if (a >= thr_low)  return SPEED_LOW;
            return SPEED_OFF;
        endfunction

        function void take_item(t_op op, t_adc adc);
            t_duty  old_duty;
            t_speed lvl;
            old_duty = duty;
            if (op == OP_SAMPLE) begin
                // samples are dropped while a kick is running
                if (kick_left == 0) begin
                    lvl = level_of(adc);
                    if (lvl != speed) begin
                        case (lvl)
                            SPEED_OFF: duty = '0;
                            SPEED_LOW: begin
                                if (speed == SPEED_OFF && kick_len != 0) begin
                                    duty      = pct_to_duty(pct_high);
                                    kick_left = kick_len;
                                    n_kicks++;
                                end else begin
                                    duty = pct_to_duty(pct_low);
                                end
                            end
                            SPEED_MID: duty = pct_to_duty(pct_mid);
                            default:   duty = pct_to_duty(pct_high);
                        endcase
                        speed = lvl;
                    end
                end
            end else if (kick_left != 0) begin
                kick_left--;
                if (kick_left == 0) duty = pct_to_duty(pct_low);
            end
            fan_state_q.push_back('{speed, duty, kick_left != 0, duty != old_duty});
        endfunction

        function string check_result(t_fan_state got);
            t_fan_state want;
            string      msg;
            if (fan_state_q.size() == 0)
                return $sformatf("result with nothing pending: speed=%0d duty=%0d",
                                 got.speed, got.duty);
            want = fan_state_q.pop_front();
            n_checked++;
            msg = "";
            if (got.speed !== want.speed)
                msg = {msg, $sformatf(" speed %0d/%0d", got.speed, want.speed)};
            if (got.duty !== want.duty)
                msg = {msg, $sformatf(" duty %0d/%0d", got.duty, want.duty)};
            if (got.kick !== want.kick)
                msg = {msg, $sformatf(" kick %b/%b", got.kick, want.kick)};
            if (got.changed !== want.changed)
                msg = {msg, $sformatf(" changed %b/%b", got.changed, want.changed)};
            if (msg != "")
                msg = $sformatf("result %0d (got/want):%s", n_checked, msg);
            return msg;
        endfunction

        function int pending();
            return fan_state_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fsk_in_if  in_ch ();
    fsk_out_if out_ch ();
    fsk_cfg_if cfg_ch ();

    fan_speed_kickstart_controller #(
        .PERIOD_REG (PERIOD_REG)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_fan_tracker tracker = new();

    t_cfg_data cfg_set [7];
    int        n_items     = 0;
    int        n_settings  = 0;
    int        n_errors    = 0;
    int        cycle_cnt   = 0;
    bit        tx_idle_en  = 1'b1;
    bit        rx_idle_en  = 1'b1;
    bit        hold_req    = 1'b0;
    bit        hold_active = 1'b0;

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // valid is left high after the transfer so back-to-back items never see a
    // low/high pair in one step; it drops only when a gap is inserted or on settle
    task automatic send_item(t_op op, t_adc adc);
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.adc_sample <= adc;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tracker.take_item(op, adc);
        n_items++;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic cfg_xfer(logic [CIDX_W-1:0] idx, t_cfg_data d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= t_cfg_idx'(idx);
        cfg_ch.data  <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        tracker.write_reg(idx, d);
    endtask

    // every register in one pass, optionally followed by a write to an
    // unmapped index that must leave the register file alone
    task automatic apply_cfg(bit with_unknown);
        for (int i = 0; i <= int'(CFG_KICK_MS); i++)
            cfg_xfer(CIDX_W'(i), cfg_set[i]);
        if (with_unknown)
            cfg_xfer(CFG_IDX_UNUSED, t_cfg_data'($urandom));
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    // input idle, all predictions retired, output register drained
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_reset_values();
        cfg_set[CFG_THRESH_LOW]  = t_cfg_data'(THRESH_LOW_RST);
        cfg_set[CFG_THRESH_MID]  = t_cfg_data'(THRESH_MID_RST);
        cfg_set[CFG_THRESH_HIGH] = t_cfg_data'(THRESH_HIGH_RST);
        cfg_set[CFG_DUTY_LOW]    = t_cfg_data'(DUTY_LOW_RST);
        cfg_set[CFG_DUTY_MID]    = t_cfg_data'(DUTY_MID_RST);
        cfg_set[CFG_DUTY_HIGH]   = t_cfg_data'(DUTY_HIGH_RST);
        cfg_set[CFG_KICK_MS]     = t_cfg_data'(KICK_MS_RST);
    endtask

    // random setting; thresholds usually ordered, percents sometimes over 100,
    // upper data bits random so the register masking gets exercised
    task automatic load_random_values();
        int unsigned a, b, c, t;
        a = $urandom_range(0, ADC_MAX);
        b = $urandom_range(0, ADC_MAX);
        c = $urandom_range(0, ADC_MAX);
        if ($urandom_range(0, 3) != 0) begin
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) begin t = a; a = b; b = t; end
        end
        cfg_set[CFG_THRESH_LOW]  = {6'($urandom), 10'(a)};
        cfg_set[CFG_THRESH_MID]  = {6'($urandom), 10'(b)};
        cfg_set[CFG_THRESH_HIGH] = {6'($urandom), 10'(c)};
        for (int i = int'(CFG_DUTY_LOW); i <= int'(CFG_DUTY_HIGH); i++)
            cfg_set[i] = {9'($urandom), ($urandom_range(0, 4) == 0) ?
                          7'($urandom_range(101, 127)) : 7'($urandom_range(0, 100))};
        cfg_set[CFG_KICK_MS] = t_cfg_data'($urandom_range(0, 24));
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------------
    function automatic t_adc near(int base);
        int v;
        v = base + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > int'(ADC_MAX)) v = ADC_MAX;
        return t_adc'(v);
    endfunction

    // half of the values around the live thresholds, where level decisions flip
    function automatic t_adc pick_adc();
        case ($urandom_range(0, 9))
            0, 1, 2: return t_adc'($urandom_range(0, ADC_MAX));
            3:       return '0;
            4:       return t_adc'(ADC_MAX);
            5, 6:    return near(tracker.thr_low);
            7:       return near(tracker.thr_mid);
            default: return near(tracker.thr_high);
        endcase
    endfunction

    // off, then speed 1 (kick if enabled), then enough ticks to run the kick
    // out, with stray samples mixed in that must be dropped while it runs
    task automatic run_kick_cycle();
        int n_ticks;
        if (tracker.thr_low > 0)
            send_item(OP_SAMPLE, t_adc'($urandom_range(0, tracker.thr_low - 1)));
        else
            send_item(OP_SAMPLE, pick_adc());
        send_item(OP_SAMPLE, t_adc'((tracker.thr_low + $urandom_range(0, 2) > ADC_MAX) ?
                  ADC_MAX : tracker.thr_low + $urandom_range(0, 2)));
        n_ticks = int'(tracker.kick_len) + $urandom_range(0, 3);
        for (int i = 0; i < n_ticks; i++) begin
            if ($urandom_range(0, 3) == 0) send_item(OP_SAMPLE, pick_adc());
            send_item(OP_TICK, t_adc'($urandom));
        end
        repeat ($urandom_range(1, 2)) send_item(OP_SAMPLE, pick_adc());
    endtask

    task automatic run_random(int count);
        int target;
        target = n_items + count;
        while (n_items < target) begin
            if ($urandom_range(0, 9) < 6) begin
                run_kick_cycle();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(t_op'($urandom_range(0, 1)), pick_adc());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sink side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : sink_driver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_active) begin
                hold_active = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_active) begin
                out_ch.ready <= 1'b0;
                if (hold_left == 0) begin
                    hold_active = 1'b0;
                    hold_req    = 1'b0;
                end else begin
                    hold_left--;
                end
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 16);
            end
        end
    end

    // result monitor: values sampled at the edge, before any update lands
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            msg = tracker.check_result('{out_ch.speed_level, out_ch.duty_count,
                                         out_ch.kick_active, out_ch.duty_changed});
            if (msg != "") report_mismatch(msg);
        end
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin : watchdog
        wait (cycle_cnt >= TIMEOUT_CYCLES);
        $display("timeout after %0d cycles, %0d predictions pending",
                 cycle_cnt, tracker.pending());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= OP_SAMPLE;
        in_ch.adc_sample <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_THRESH_LOW;
        cfg_ch.data      <= '0;
        i_rst_n          <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values, nothing written yet
        send_item(OP_SAMPLE, 10'd0);      // already off: no change
        send_item(OP_TICK,   10'd0);      // tick with no kick running
        send_item(OP_SAMPLE, 10'd1023);   // straight to speed 3
        send_item(OP_SAMPLE, 10'd1023);   // same level
        send_item(OP_SAMPLE, 10'd601);    // speed 2 at its threshold
        send_item(OP_SAMPLE, 10'd401);    // down to speed 1, no kick from above
        send_item(OP_SAMPLE, 10'd400);    // just below: off

        // short kick, stray write to an unmapped index
        settle();
        load_reset_values();
        cfg_set[CFG_KICK_MS] = 16'd3;
        apply_cfg(1'b1);
        send_item(OP_SAMPLE, 10'd401);    // off -> 1 starts the kick at high duty
        send_item(OP_SAMPLE, 10'd1023);   // dropped during the kick
        send_item(OP_TICK,   10'd0);
        send_item(OP_TICK,   10'd0);
        send_item(OP_TICK,   10'd1023);   // kick ends, low duty
        send_item(OP_TICK,   10'd0);
        send_item(OP_SAMPLE, 10'd0);

        // low duty equal to the kick duty: end of kick changes nothing;
        // high percent written as 127 saturates to 100 percent
        settle();
        cfg_set[CFG_DUTY_LOW]  = 16'd100;
        cfg_set[CFG_DUTY_HIGH] = 16'h00FF;
        cfg_set[CFG_KICK_MS]   = 16'd2;
        apply_cfg(1'b0);
        send_item(OP_SAMPLE, 10'd500);
        send_item(OP_TICK,   10'd0);
        send_item(OP_TICK,   10'd0);
        send_item(OP_SAMPLE, 10'd0);

        // unordered thresholds, kick disabled, mid percent zero
        settle();
        cfg_set[CFG_THRESH_LOW]  = 16'd50;
        cfg_set[CFG_THRESH_MID]  = 16'd900;
        cfg_set[CFG_THRESH_HIGH] = 16'd500;
        cfg_set[CFG_DUTY_MID]    = 16'd0;
        cfg_set[CFG_KICK_MS]     = 16'd0;
        apply_cfg(1'b0);
        send_item(OP_SAMPLE, 10'd60);     // speed 1 with no kick
        send_item(OP_SAMPLE, 10'd950);    // high wins over mid
        send_item(OP_SAMPLE, 10'd700);
        send_item(OP_SAMPLE, 10'd10);

        // back-pressure: sink holds off while items keep coming
        settle();
        load_reset_values();
        cfg_set[CFG_KICK_MS] = 16'd4;
        apply_cfg(1'b0);
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        wait (hold_active);
        repeat (24) send_item(t_op'($urandom_range(0, 1)), pick_adc());
        tx_idle_en = 1'b1;

        // randomized settings, reset values and extremes first
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            case (p)
                0: load_reset_values();
                1: begin
                    for (int i = 0; i <= int'(CFG_KICK_MS); i++) cfg_set[i] = '0;
                end
                2: begin
                    cfg_set[CFG_THRESH_LOW]  = 16'hFFFF;
                    cfg_set[CFG_THRESH_MID]  = 16'hFFFF;
                    cfg_set[CFG_THRESH_HIGH] = 16'hFFFF;
                    cfg_set[CFG_DUTY_LOW]    = 16'hFFFF;
                    cfg_set[CFG_DUTY_MID]    = 16'hFFFF;
                    cfg_set[CFG_DUTY_HIGH]   = 16'hFFFF;
                    cfg_set[CFG_KICK_MS]     = 16'd1;
                end
                default: load_random_values();
            endcase
            apply_cfg($urandom_range(0, 3) == 0);
            run_random(PHASE_ITEMS);
        end

        // final stretch, no idling on either side: long kick run to the end
        settle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        load_reset_values();
        cfg_set[CFG_DUTY_LOW] = t_cfg_data'($urandom_range(0, 100));
        cfg_set[CFG_KICK_MS]  = t_cfg_data'(FINAL_KICK);
        apply_cfg(1'b0);
        send_item(OP_SAMPLE, 10'd0);
        send_item(OP_SAMPLE, THRESH_LOW_RST);
        for (int i = 0; i <= FINAL_KICK; i++) begin
            if (i % 8 == 0) send_item(OP_SAMPLE, t_adc'($urandom));
            send_item(OP_TICK, t_adc'($urandom));
        end
        send_item(OP_SAMPLE, 10'd1023);

        settle();
        load_random_values();
        apply_cfg(1'b1);
        run_random(100);

        settle();
        $display("Run covered %0d items over %0d register settings, %0d kick-starts.",
                 n_items, n_settings, tracker.n_kicks);
        $display("%0d results checked, %0d mismatches, %0d cycles.",
                 tracker.n_checked, n_errors, cycle_cnt);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/fsk_pkg.sv
design/fsk_if.sv
design/fan_speed_kickstart_controller.sv
design/fsk_checker.sv
sim/fan_speed_kickstart_controller_tb.sv
